@@ src/mlr_pkg.sv @@
// shared widths and the line setup record for the midpoint line rasterizer
`timescale 1ns / 1ps

package mlr_pkg;

    // coordinate width of endpoints, cursor and span count
    localparam int COORD_BITS = 12;
    // signed width of the decision value and its increments (covers +/- 2 * span)
    localparam int DEC_BITS = COORD_BITS + 2;
    // color word width
    localparam int COLOR_BITS = 32;

    // unit step on a coordinate
    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    // command codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // everything a start request loads into the stepping state
    typedef struct packed {
        logic [COORD_BITS-1:0]      cursor_x;
        logic [COORD_BITS-1:0]      cursor_y;
        logic signed [DEC_BITS-1:0] decision;
        logic signed [DEC_BITS-1:0] straight_increment;
        logic signed [DEC_BITS-1:0] diagonal_increment;
        logic [COORD_BITS-1:0]      steps_left;
        logic                       major_is_x;
        logic                       minor_down;
    } line_setup_t;

endpackage

@@ src/mlr_setup.sv @@
// endpoint ordering, axis choice and decision setup for a new line
`timescale 1ns / 1ps

module mlr_setup (
    input  logic [mlr_pkg::COORD_BITS-1:0] x0,
    input  logic [mlr_pkg::COORD_BITS-1:0] y0,
    input  logic [mlr_pkg::COORD_BITS-1:0] x1,
    input  logic [mlr_pkg::COORD_BITS-1:0] y1,
    output mlr_pkg::line_setup_t           setup
);

    logic [mlr_pkg::COORD_BITS-1:0] dx;
    logic [mlr_pkg::COORD_BITS-1:0] dy;
    logic [mlr_pkg::COORD_BITS-1:0] dmaj;
    logic [mlr_pkg::COORD_BITS-1:0] dmin;
    logic [mlr_pkg::COORD_BITS-1:0] xa;
    logic [mlr_pkg::COORD_BITS-1:0] ya;
    logic [mlr_pkg::COORD_BITS-1:0] xb;
    logic [mlr_pkg::COORD_BITS-1:0] yb;
    logic                           major_is_x;
    logic                           swap;
    logic signed [mlr_pkg::DEC_BITS-1:0] dmaj_s;
    logic signed [mlr_pkg::DEC_BITS-1:0] dmin2_s;

    // absolute spans
    assign dx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    assign dy = (y1 >= y0) ? (y1 - y0) : (y0 - y1);

    // x is major only when strictly longer; equal spans go to y
    assign major_is_x = dx > dy;
    assign swap       = major_is_x ? (x1 < x0) : (y1 < y0);

    // order endpoints so the major coordinate rises
    assign xa = swap ? x1 : x0;
    assign ya = swap ? y1 : y0;
    assign xb = swap ? x0 : x1;
    assign yb = swap ? y0 : y1;

    assign dmaj = major_is_x ? dx : dy;
    assign dmin = major_is_x ? dy : dx;

    assign dmaj_s  = $signed({{(mlr_pkg::DEC_BITS - mlr_pkg::COORD_BITS){1'b0}}, dmaj});
    assign dmin2_s = $signed({1'b0, dmin, 1'b0});

    // setup record
    always_comb
    begin
        setup.cursor_x           = xa;
        setup.cursor_y           = ya;
        setup.decision           = dmaj_s - dmin2_s;
        setup.straight_increment = -dmin2_s;
        setup.diagonal_increment = $signed({1'b0, dmaj, 1'b0}) - dmin2_s;
        setup.steps_left         = dmaj;
        setup.major_is_x         = major_is_x;
        setup.minor_down         = major_is_x ? (yb < ya) : (xb < xa);
    end

endmodule

@@ src/midpoint_line_rasterizer_top.sv @@
// top level of the midpoint line rasterizer: stepping state and pixel output register
`timescale 1ns / 1ps

// Midpoint line rasterizer. A start request (operation 0) takes two endpoints and a
// color and emits the first pixel of the line; each step request (operation 1) emits
// the next pixel along the major axis, with last_pixel set on the end point. A step
// while no line is active is taken and produces no pixel; a start abandons any line in
// progress. Every request is handled in the cycle it is accepted: the decision update
// is one add and a sign test on the stepping registers, so one request per clock is
// accepted and one pixel per clock leaves while out_ready stays high, and the pixel
// appears on the output register in the cycle after its request. The output register
// lets a new request in while the previous pixel is still waiting, as long as that
// pixel is taken the same cycle.

module midpoint_line_rasterizer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [mlr_pkg::COORD_BITS-1:0]  x0,
    input  logic [mlr_pkg::COORD_BITS-1:0]  y0,
    input  logic [mlr_pkg::COORD_BITS-1:0]  x1,
    input  logic [mlr_pkg::COORD_BITS-1:0]  y1,
    input  logic [mlr_pkg::COLOR_BITS-1:0]  line_color,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mlr_pkg::COORD_BITS-1:0]  pixel_x,
    output logic [mlr_pkg::COORD_BITS-1:0]  pixel_y,
    output logic [mlr_pkg::COLOR_BITS-1:0]  pixel_color,
    output logic                            last_pixel
);

    // stepping state
    logic [mlr_pkg::COORD_BITS-1:0]      cursor_x_reg,  cursor_x_next;
    logic [mlr_pkg::COORD_BITS-1:0]      cursor_y_reg,  cursor_y_next;
    logic signed [mlr_pkg::DEC_BITS-1:0] decision_reg,  decision_next;
    logic signed [mlr_pkg::DEC_BITS-1:0] straight_reg,  straight_next;
    logic signed [mlr_pkg::DEC_BITS-1:0] diagonal_reg,  diagonal_next;
    logic [mlr_pkg::COORD_BITS-1:0]      steps_reg,     steps_next;
    logic                                major_x_reg,   major_x_next;
    logic                                minor_down_reg, minor_down_next;
    logic [mlr_pkg::COLOR_BITS-1:0]      color_reg,     color_next;
    logic                                busy_reg,      busy_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [mlr_pkg::COORD_BITS-1:0]      pixel_x_reg;
    logic [mlr_pkg::COORD_BITS-1:0]      pixel_y_reg;
    logic [mlr_pkg::COLOR_BITS-1:0]      pixel_color_reg;
    logic                                last_pixel_reg;

    mlr_pkg::line_setup_t                setup;
    logic                                accept;
    logic                                emit;
    logic [mlr_pkg::COORD_BITS-1:0]      minor_coord;
    logic [mlr_pkg::COORD_BITS-1:0]      minor_moved;

    mlr_setup u_setup (
        .x0    (x0),
        .y0    (y0),
        .x1    (x1),
        .y1    (y1),
        .setup (setup)
    );

    // take a request whenever the output slot is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign emit     = accept && ((operation == mlr_pkg::OP_START) || busy_reg);

    // minor coordinate moved one toward the end point
    assign minor_coord = major_x_reg ? cursor_y_reg : cursor_x_reg;
    assign minor_moved = minor_down_reg ? (minor_coord - mlr_pkg::COORD_ONE)
                                        : (minor_coord + mlr_pkg::COORD_ONE);

    // next state for start and step requests
    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        decision_next   = decision_reg;
        straight_next   = straight_reg;
        diagonal_next   = diagonal_reg;
        steps_next      = steps_reg;
        major_x_next    = major_x_reg;
        minor_down_next = minor_down_reg;
        color_next      = color_reg;
        busy_next       = busy_reg;
        if (accept)
        begin
            if (operation == mlr_pkg::OP_START)
            begin
                cursor_x_next   = setup.cursor_x;
                cursor_y_next   = setup.cursor_y;
                decision_next   = setup.decision;
                straight_next   = setup.straight_increment;
                diagonal_next   = setup.diagonal_increment;
                steps_next      = setup.steps_left;
                major_x_next    = setup.major_is_x;
                minor_down_next = setup.minor_down;
                color_next      = line_color;
                busy_next       = setup.steps_left != '0;
            end
            else if (busy_reg)
            begin
                // negative decision moves the minor axis; zero keeps it
                if (decision_reg[mlr_pkg::DEC_BITS-1])
                begin
                    if (major_x_reg)
                        cursor_y_next = minor_moved;
                    else
                        cursor_x_next = minor_moved;
                    decision_next = decision_reg + diagonal_reg;
                end
                else
                begin
                    decision_next = decision_reg + straight_reg;
                end
                if (major_x_reg)
                    cursor_x_next = cursor_x_reg + mlr_pkg::COORD_ONE;
                else
                    cursor_y_next = cursor_y_reg + mlr_pkg::COORD_ONE;
                steps_next = steps_reg - mlr_pkg::COORD_ONE;
                busy_next  = steps_reg != mlr_pkg::COORD_ONE;
            end
        end
    end

    // output slot fills on an emitted pixel and drains when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            decision_reg   <= '0;
            straight_reg   <= '0;
            diagonal_reg   <= '0;
            steps_reg      <= '0;
            major_x_reg    <= 1'b0;
            minor_down_reg <= 1'b0;
            color_reg      <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            decision_reg   <= decision_next;
            straight_reg   <= straight_next;
            diagonal_reg   <= diagonal_next;
            steps_reg      <= steps_next;
            major_x_reg    <= major_x_next;
            minor_down_reg <= minor_down_next;
            color_reg      <= color_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // pixel payload, loaded with the new cursor
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg     <= cursor_x_next;
            pixel_y_reg     <= cursor_y_next;
            pixel_color_reg <= color_next;
            last_pixel_reg  <= !busy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule
